@@ hdl/bsw_pkg.sv @@
// ----------------------------------------------------------------------------
// bsw_pkg: shared types and constants
// Tick kinds, motion codes and the word layouts of the stepper wave drive.
// ----------------------------------------------------------------------------
`default_nettype none

package bsw_pkg;

    localparam int unsigned CountW       = 8;
    localparam int unsigned PosW         = 3;
    localparam int unsigned CoilW        = 4;
    localparam int unsigned SDataW       = 8;
    localparam int unsigned SUserW       = 2;
    localparam int unsigned MDataW       = 8;

    localparam logic [CountW-1:0] DebounceReset = 8'd4;
    localparam logic [PosW-1:0]   PosFirst      = 3'd1;
    localparam logic [PosW-1:0]   PosLast       = 3'd4;

    // tick kind carried in tuser
    typedef enum logic [1:0] {
        FUNC_SAMPLE  = 2'd0,
        FUNC_RELEASE = 2'd1,
        FUNC_STEP    = 2'd2,
        FUNC_NOP     = 2'd3
    } func_t;

    // motion mode; MODE_NONE marks an empty latched choice
    typedef enum logic [1:0] {
        MODE_STOP = 2'd0,
        MODE_CW   = 2'd1,
        MODE_CCW  = 2'd2,
        MODE_NONE = 2'd3
    } mode_t;

    typedef struct packed {
        func_t func;
        logic  stop;
        logic  cw;
        logic  ccw;
    } tick_t;

    typedef struct packed {
        logic              pending;
        mode_t             mode;
        logic [CoilW-1:0]  coil;
    } result_t;

endpackage

`default_nettype wire

@@ hdl/button_stepper_wave_drive.sv @@
// ----------------------------------------------------------------------------
// button_stepper_wave_drive: three-button stepper controller, wave drive
// Debounces stop/cw/ccw buttons, adopts a choice on release and steps a
// four-coil motor one phase at a time. One status word per tick word.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                  | words
//  ---------+-----+------------------------------------------+-----------------
//  s_       | in  | tuser: func; tdata: stop, cw, ccw        | one tick
//  m_       | out | tdata: coil_drive, motion_mode, pending  | one per tick
//  cfg_     | in  | debounce_ticks, write-only               | n/a
//
//  Throughput: one tick word per clock while m_tready holds high; after the
//  input handshake a word passes the input register, then the result
//  register, and m_tvalid rises once the result register holds it.
//  Reset: aresetn low clears both stages and the control state; the
//  debounce count returns to 4.
//  Stalls: m_tready low holds the result; the input register keeps
//  accepting until it is full, so s_tready drops one word later.
// ----------------------------------------------------------------------------
`default_nettype none

module button_stepper_wave_drive (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    // configuration
    input  wire logic                       cfg_wr_en,
    input  wire logic [bsw_pkg::CountW-1:0] cfg_wr_data,  // debounce_ticks
    // tick input
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bsw_pkg::SDataW-1:0] s_tdata,  // [0] stop, [1] cw, [2] ccw
    input  wire logic [bsw_pkg::SUserW-1:0] s_tuser,  // [1:0] func
    // status output
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [bsw_pkg::MDataW-1:0]      m_tdata   // [3:0] coil, [5:4] mode, [6] pend
);
    import bsw_pkg::*;

    logic    in_vld;
    logic    fire;       // tick moves from input register into the state
    tick_t   tick;
    result_t cur;        // state before the tick
    result_t nxt;        // state after the tick, loaded into the result register

    bsw_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .take     (fire),
        .vld      (in_vld),
        .tick     (tick)
    );

    // debounce, release check and coil sequencer; state advances on fire
    bsw_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .fire        (fire),
        .tick        (tick),
        .cur         (cur),
        .nxt         (nxt)
    );

    // result register; frees itself in the cycle the sink takes the word
    bsw_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_vld   (in_vld),
        .res      (nxt),
        .fire     (fire),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // empty result register never blocks the input side
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty result register");

    // wave drive: at most one coil energized
    a_one_coil: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $onehot0(m_tdata[CoilW-1:0]))
        else $error("more than one coil energized");

    // coils move only on a step tick
    a_coil_only_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && tick.func != FUNC_STEP) |-> (nxt.coil == cur.coil))
        else $error("coils changed outside a step tick");

    // a pending choice is cleared only by a release check
    a_pend_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && tick.func != FUNC_RELEASE && cur.pending) |-> nxt.pending)
        else $error("pending choice dropped without release tick");

endmodule

`default_nettype wire

@@ hdl/bsw_in_stage.sv @@
// ----------------------------------------------------------------------------
// bsw_in_stage: input register
// Captures one tick word; refills in the same cycle it is consumed.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_in_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [bsw_pkg::SDataW-1:0] s_tdata,
    input  wire logic [bsw_pkg::SUserW-1:0] s_tuser,
    input  wire logic                       take,
    output logic                            vld,
    output bsw_pkg::tick_t                  tick
);
    import bsw_pkg::*;

    logic  vld_reg, vld_next;
    tick_t tick_reg;

    assign s_tready = !vld_reg || take;
    assign vld      = vld_reg;
    assign tick     = tick_reg;

    always_comb begin
        vld_next = vld_reg;
        if (s_tvalid && s_tready) begin
            vld_next = 1'b1;
        end else if (take) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tick_reg <= '{func: func_t'(s_tuser), stop: s_tdata[0],
                          cw: s_tdata[1], ccw: s_tdata[2]};
        end
    end

endmodule

`default_nettype wire

@@ hdl/bsw_core.sv @@
// ----------------------------------------------------------------------------
// bsw_core: debounce, release check and wave sequencer
// Holds the control state and computes its next value for one tick.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_core (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [bsw_pkg::CountW-1:0] cfg_wr_data,
    input  wire logic                       fire,
    input  wire bsw_pkg::tick_t             tick,
    output bsw_pkg::result_t                cur,
    output bsw_pkg::result_t                nxt
);
    import bsw_pkg::*;

    logic [CountW-1:0] deb_reg;
    logic [CountW-1:0] hold_reg, hold_next;
    logic              pend_reg, pend_next;
    mode_t             latch_reg, latch_next;
    mode_t             mode_reg, mode_next;
    logic [PosW-1:0]   cw_pos_reg, cw_pos_next;
    logic [PosW-1:0]   ccw_pos_reg, ccw_pos_next;
    logic [CoilW-1:0]  coil_reg, coil_next;

    logic [CountW-1:0] hold_inc;
    logic [PosW-1:0]   cw_p, ccw_p;
    logic [PosW-1:0]   cw_bit, ccw_bit;

    assign hold_inc = hold_reg + 1'b1;
    assign cw_p     = cw_pos_reg + 1'b1;
    assign ccw_p    = ccw_pos_reg + 1'b1;
    assign cw_bit   = cw_p - PosFirst;
    assign ccw_bit  = PosLast - ccw_p;

    always_comb begin
        hold_next    = hold_reg;
        pend_next    = pend_reg;
        latch_next   = latch_reg;
        mode_next    = mode_reg;
        cw_pos_next  = cw_pos_reg;
        ccw_pos_next = ccw_pos_reg;
        coil_next    = coil_reg;
        unique case (tick.func)
            FUNC_SAMPLE: begin
                if (!pend_reg) begin
                    if (tick.stop || tick.cw || tick.ccw) begin
                        hold_next = hold_inc;
                        if (hold_inc == deb_reg) begin
                            pend_next = 1'b1;
                            hold_next = '0;
                            priority if (tick.stop) begin
                                latch_next = MODE_STOP;
                            end else if (tick.cw) begin
                                latch_next = MODE_CW;
                            end else begin
                                latch_next = MODE_CCW;
                            end
                        end
                    end else begin
                        hold_next = '0;
                    end
                end
            end
            FUNC_RELEASE: begin
                if (pend_reg) begin
                    priority if (!tick.stop && latch_reg == MODE_STOP) begin
                        mode_next = MODE_STOP;
                        pend_next = 1'b0;
                    end else if (!tick.cw && latch_reg == MODE_CW) begin
                        mode_next = MODE_CW;
                        pend_next = 1'b0;
                    end else if (!tick.ccw && latch_reg == MODE_CCW) begin
                        mode_next = MODE_CCW;
                        pend_next = 1'b0;
                    end
                end
            end
            FUNC_STEP: begin
                priority if (mode_reg == MODE_CW) begin
                    if (cw_p >= PosFirst && cw_p <= PosLast) begin
                        coil_next   = CoilW'(1) << cw_bit;
                        cw_pos_next = cw_p;
                    end else begin
                        cw_pos_next = '0;   // fifth position holds coils
                    end
                end else if (mode_reg == MODE_CCW) begin
                    if (ccw_p >= PosFirst && ccw_p <= PosLast) begin
                        coil_next    = CoilW'(1) << ccw_bit;
                        ccw_pos_next = ccw_p;
                    end else begin
                        ccw_pos_next = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign cur = '{pending: pend_reg,  mode: mode_reg,  coil: coil_reg};
    assign nxt = '{pending: pend_next, mode: mode_next, coil: coil_next};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_reg <= DebounceReset;
        end else if (cfg_wr_en) begin
            deb_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg    <= '0;
            pend_reg    <= 1'b0;
            latch_reg   <= MODE_NONE;
            mode_reg    <= MODE_STOP;
            cw_pos_reg  <= '0;
            ccw_pos_reg <= '0;
            coil_reg    <= '0;
        end else if (fire) begin
            hold_reg    <= hold_next;
            pend_reg    <= pend_next;
            latch_reg   <= latch_next;
            mode_reg    <= mode_next;
            cw_pos_reg  <= cw_pos_next;
            ccw_pos_reg <= ccw_pos_next;
            coil_reg    <= coil_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/bsw_out_stage.sv @@
// ----------------------------------------------------------------------------
// bsw_out_stage: result register
// Holds one status word until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bsw_out_stage (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_vld,
    input  wire bsw_pkg::result_t           res,
    output logic                            fire,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [bsw_pkg::MDataW-1:0]      m_tdata
);
    import bsw_pkg::*;

    logic    vld_reg, vld_next;
    result_t res_reg;

    assign fire     = in_vld && (!vld_reg || m_tready);
    assign m_tvalid = vld_reg;
    assign m_tdata  = {{(MDataW - $bits(result_t)){1'b0}}, res_reg};

    always_comb begin
        vld_next = vld_reg;
        if (fire) begin
            vld_next = 1'b1;
        end else if (m_tready) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg <= res;
        end
    end

endmodule

`default_nettype wire
